/* hw/rtl/ece_pkg.sv */
package ece_pkg;

    // fixed-point grid: 2^FRAC_BITS means 1.0
    localparam int FRAC_BITS = 15;
    localparam int IN_W      = 16;
    localparam int OUT_W     = 16;
    localparam int VAL_W     = FRAC_BITS + 1;
    localparam int MAX_POW   = 5;
    localparam int PROD_W    = MAX_POW * VAL_W;
    localparam int SHIFT_W   = $clog2((MAX_POW - 1) * FRAC_BITS + 1);
    localparam int MODE_W    = 4;

    localparam logic [VAL_W-1:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [VAL_W-1:0] HALF = {2'b01, {(FRAC_BITS-1){1'b0}}};

    // curve mode codes
    localparam logic [MODE_W-1:0] MODE_NONE        = 4'd0;
    localparam logic [MODE_W-1:0] MODE_LINEAR      = 4'd1;
    localparam logic [MODE_W-1:0] MODE_QUAD_IN     = 4'd2;
    localparam logic [MODE_W-1:0] MODE_QUAD_OUT    = 4'd3;
    localparam logic [MODE_W-1:0] MODE_QUAD_INOUT  = 4'd4;
    localparam logic [MODE_W-1:0] MODE_CUBIC_IN    = 4'd5;
    localparam logic [MODE_W-1:0] MODE_CUBIC_OUT   = 4'd6;
    localparam logic [MODE_W-1:0] MODE_CUBIC_INOUT = 4'd7;
    localparam logic [MODE_W-1:0] MODE_QUART_IN    = 4'd8;
    localparam logic [MODE_W-1:0] MODE_QUART_OUT   = 4'd9;
    localparam logic [MODE_W-1:0] MODE_QUART_INOUT = 4'd10;
    localparam logic [MODE_W-1:0] MODE_QUINT_IN    = 4'd11;
    localparam logic [MODE_W-1:0] MODE_QUINT_OUT   = 4'd12;
    localparam logic [MODE_W-1:0] MODE_QUINT_INOUT = 4'd13;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_LINEAR,
        KIND_POLY
    } t_kind;

    // one word in flight through the power pipeline
    typedef struct packed {
        logic               valid;
        logic               curve_valid;
        t_kind              kind;
        logic [2:0]         pow_n;
        logic               up;
        logic [SHIFT_W-1:0] shift;
        logic [VAL_W-1:0]   x;
        logic [VAL_W-1:0]   v;
        logic [PROD_W-1:0]  prod;
    } t_pipe;

endpackage

/* hw/rtl/ece_front.sv */
module ece_front
    import ece_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic [IN_W-1:0]   i_progress,
    input  logic [MODE_W-1:0] i_mode,
    output t_pipe             o_stage
);

    typedef enum logic [1:0] {
        SHAPE_IN,
        SHAPE_OUT,
        SHAPE_INOUT
    } t_shape;

    t_pipe              n_stage;
    t_pipe              r_stage;
    t_shape             shape;
    logic [VAL_W-1:0]   x;
    logic [VAL_W-1:0]   u;
    logic [2:0]         k;
    logic [SHIFT_W-1:0] sh_base;

    always_comb begin
        // saturate progress to 1.0
        if ({16'd0, i_progress} > 32'(ONE)) begin
            x = ONE;
        end else begin
            x = VAL_W'(i_progress);
        end
        u = ONE - x;

        n_stage             = '0;
        n_stage.valid       = i_take;
        n_stage.curve_valid = 1'b1;
        n_stage.kind        = KIND_POLY;
        n_stage.x           = x;
        shape               = SHAPE_IN;

        case (i_mode)
            MODE_LINEAR:      begin n_stage.kind = KIND_LINEAR; end
            MODE_QUAD_IN:     begin n_stage.pow_n = 3'd2; shape = SHAPE_IN;    end
            MODE_QUAD_OUT:    begin n_stage.pow_n = 3'd2; shape = SHAPE_OUT;   end
            MODE_QUAD_INOUT:  begin n_stage.pow_n = 3'd2; shape = SHAPE_INOUT; end
            MODE_CUBIC_IN:    begin n_stage.pow_n = 3'd3; shape = SHAPE_IN;    end
            MODE_CUBIC_OUT:   begin n_stage.pow_n = 3'd3; shape = SHAPE_OUT;   end
            MODE_CUBIC_INOUT: begin n_stage.pow_n = 3'd3; shape = SHAPE_INOUT; end
            MODE_QUART_IN:    begin n_stage.pow_n = 3'd4; shape = SHAPE_IN;    end
            MODE_QUART_OUT:   begin n_stage.pow_n = 3'd4; shape = SHAPE_OUT;   end
            MODE_QUART_INOUT: begin n_stage.pow_n = 3'd4; shape = SHAPE_INOUT; end
            MODE_QUINT_IN:    begin n_stage.pow_n = 3'd5; shape = SHAPE_IN;    end
            MODE_QUINT_OUT:   begin n_stage.pow_n = 3'd5; shape = SHAPE_OUT;   end
            MODE_QUINT_INOUT: begin n_stage.pow_n = 3'd5; shape = SHAPE_INOUT; end
            default: begin
                n_stage.kind        = KIND_NONE;
                n_stage.curve_valid = 1'b0;
            end
        endcase

        // pick base, direction of rounding and the 2^(n-1) in-out gain
        k = 3'd0;
        case (shape)
            SHAPE_IN: begin
                n_stage.v  = x;
                n_stage.up = 1'b0;
            end
            SHAPE_OUT: begin
                n_stage.v  = u;
                n_stage.up = 1'b1;
            end
            default: begin
                k = n_stage.pow_n - 3'd1;
                if (x < HALF) begin
                    n_stage.v  = x;
                    n_stage.up = 1'b0;
                end else begin
                    n_stage.v  = u;
                    n_stage.up = 1'b1;
                end
            end
        endcase

        case (n_stage.pow_n)
            3'd2:    sh_base = SHIFT_W'(FRAC_BITS);
            3'd3:    sh_base = SHIFT_W'(2 * FRAC_BITS);
            3'd4:    sh_base = SHIFT_W'(3 * FRAC_BITS);
            3'd5:    sh_base = SHIFT_W'(4 * FRAC_BITS);
            default: sh_base = '0;
        endcase
        n_stage.shift = sh_base - SHIFT_W'(k);
        n_stage.prod  = PROD_W'(n_stage.v);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

/* hw/rtl/ece_mul.sv */
module ece_mul
    import ece_pkg::*;
#(
    parameter int STAGE_POW = 2
)
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_pipe i_stage,
    output t_pipe o_stage
);

    localparam int MUL_IN_W  = (STAGE_POW - 1) * VAL_W;
    localparam int MUL_OUT_W = MUL_IN_W + VAL_W;

    t_pipe                n_stage;
    t_pipe                r_stage;
    logic [MUL_OUT_W-1:0] mul_res;

    // running power times base, only while the word still needs a factor
    assign mul_res = i_stage.prod[MUL_IN_W-1:0] * i_stage.v;

    always_comb begin
        n_stage = i_stage;
        if (i_stage.pow_n >= 3'(STAGE_POW)) begin
            n_stage.prod = PROD_W'(mul_res);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

/* hw/rtl/ece_round.sv */
module ece_round
    import ece_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_pipe            i_stage,
    output logic             o_strobe,
    output logic [OUT_W-1:0] o_eased_value,
    output logic             o_curve_valid
);

    typedef struct packed {
        logic             valid;
        logic             curve_valid;
        t_kind            kind;
        logic             up;
        logic [VAL_W-1:0] x;
        logic [VAL_W-1:0] q;
        logic             rem;
    } t_rnd;

    t_rnd              n_rnd;
    t_rnd              r_rnd;
    logic [PROD_W-1:0] shifted;
    logic [PROD_W-1:0] low_mask;
    logic [VAL_W-1:0]  n_value;
    logic              r_strobe;
    logic [OUT_W-1:0]  r_eased_value;
    logic              r_curve_valid;

    // quotient and sticky remainder of the scaled power
    always_comb begin
        shifted           = i_stage.prod >> i_stage.shift;
        low_mask          = ~({PROD_W{1'b1}} << i_stage.shift);
        n_rnd.valid       = i_stage.valid;
        n_rnd.curve_valid = i_stage.curve_valid;
        n_rnd.kind        = i_stage.kind;
        n_rnd.up          = i_stage.up;
        n_rnd.x           = i_stage.x;
        n_rnd.q           = shifted[VAL_W-1:0];
        n_rnd.rem         = |(i_stage.prod & low_mask);
    end

    always_comb begin
        case (r_rnd.kind)
            KIND_LINEAR: n_value = r_rnd.x;
            KIND_POLY: begin
                if (r_rnd.up) begin
                    n_value = ONE - (r_rnd.q + VAL_W'(r_rnd.rem));
                end else begin
                    n_value = r_rnd.q;
                end
            end
            default:     n_value = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rnd.valid <= 1'b0;
            r_strobe    <= 1'b0;
        end else begin
            r_rnd         <= n_rnd;
            r_strobe      <= r_rnd.valid;
            r_eased_value <= OUT_W'(n_value);
            r_curve_valid <= r_rnd.curve_valid;
        end
    end

    assign o_strobe      = r_strobe;
    assign o_eased_value = r_eased_value;
    assign o_curve_valid = r_curve_valid;

endmodule

/* hw/rtl/easing_curve_evaluator.sv */
// easing curve evaluator: linear and quad/cubic/quart/quint in, out, in-out
// start passes the front, multiply and round registers before the strobe
// throughput: one word per cycle through the seven-stage pipeline
// busy is always low and the receiver cannot stall: one strobe per word taken
// reset (synchronous, active low) empties the pipeline and sets curve mode to none
module easing_curve_evaluator
    import ece_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [IN_W-1:0]   i_progress,
    input  logic              i_cfg_we,
    input  logic [MODE_W-1:0] i_cfg_data,
    output logic              o_strobe,
    output logic [OUT_W-1:0]  o_eased_value,
    output logic              o_curve_valid
);

    // curve mode register; user writes only while pipeline is empty, unenforced
    logic [MODE_W-1:0] r_curve_mode;

    // stage taps: front decode, then one running-power multiply per stage
    t_pipe s_front;
    t_pipe s_pow2;
    t_pipe s_pow3;
    t_pipe s_pow4;
    t_pipe s_pow5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_curve_mode <= MODE_NONE;
        end else if (i_cfg_we) begin
            r_curve_mode <= i_cfg_data;
        end
    end

    // every stage moves each cycle, so a new word is always welcome
    assign busy = 1'b0;

    // stage 1: saturate t, decode mode, pick base (t or 1-t), rounding and shift
    ece_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (start),
        .i_progress (i_progress),
        .i_mode     (r_curve_mode),
        .o_stage    (s_front)
    );

    // stages 2 to 5: v^2 .. v^5, held once the word's power is reached
    ece_mul #(.STAGE_POW(2)) u_mul2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stage (s_front),
        .o_stage (s_pow2)
    );

    ece_mul #(.STAGE_POW(3)) u_mul3 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stage (s_pow2),
        .o_stage (s_pow3)
    );

    ece_mul #(.STAGE_POW(4)) u_mul4 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stage (s_pow3),
        .o_stage (s_pow4)
    );

    ece_mul #(.STAGE_POW(5)) u_mul5 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stage (s_pow4),
        .o_stage (s_pow5)
    );

    // stages 6 and 7: exact floor or ceiling of the scaled power, then 1 minus it
    // for out curves and the upper in-out half; result register drives the ports
    ece_round u_round (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_stage       (s_pow5),
        .o_strobe      (o_strobe),
        .o_eased_value (o_eased_value),
        .o_curve_valid (o_curve_valid)
    );

endmodule
